// File: src/trimmed_mean_of_five_assert.svh
// Assertion macros for the trimmed mean filter.
`ifndef TRIMMED_MEAN_OF_FIVE_ASSERT_SVH
`define TRIMMED_MEAN_OF_FIVE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMOF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tmof_pkg.sv
// Constants for the trimmed mean of five filter.
package tmof_pkg;

    localparam int CHANNELS_DEF    = 12;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int WINDOW_LEN = 5;
    localparam int HELD_LEN   = 4;
    localparam int KEPT_LEN   = WINDOW_LEN - 2;

    localparam int CHAN_W      = 4;
    localparam int SAMPLE_IN_W = 12;
    localparam int MEAN_W      = 12;
    localparam int COUNT_W     = 3;
    localparam int DATA_W      = ((SAMPLE_IN_W + 7) / 8) * 8;
    localparam int MDATA_W     = ((MEAN_W + 7) / 8) * 8;

endpackage

// File: src/trimmed_mean_of_five.sv
// Per-channel trimmed mean of five: top level.
//
//  channel   dir  tdata                         tuser
//  s_axis    in   sample[11:0], zero pad to 16  channel[3:0]
//  m_axis    out  mean[11:0], zero pad to 16    out_channel[3:0]
//
// Each item passes the input register, then min/max, sum and a reciprocal
// multiply by a third into the result register.
// One item per cycle unless stalled; the channel's window state is read and written
// in the second stage, so items for the same channel may follow back to back.
// A stalled result blocks only items that complete a window; others flow on.
// Synchronous active-low reset clears the window counts; held samples are not reset.
module trimmed_mean_of_five
    import tmof_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [DATA_W-1:0]  i_s_axis_tdata,   // [11:0] sample
    input  logic [CHAN_W-1:0]  i_s_axis_tuser,   // [3:0] channel
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [MDATA_W-1:0] o_m_axis_tdata,   // [11:0] mean
    output logic [CHAN_W-1:0]  o_m_axis_tuser    // [3:0] out_channel
);

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W    = $clog2(HELD_LEN);
    localparam int EXT_W     = (SAMPLE_BITS > SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
    localparam int TOTAL_W   = SAMPLE_BITS + 3;
    localparam int SUM_W     = SAMPLE_BITS + 2;
    // odd shift makes 2^s + 1 divisible by three; exact for sums below 2^s
    localparam int DIV_SHIFT = SUM_W + ((SUM_W + 1) % 2);
    localparam longint DIV_MULT = ((64'd1 << DIV_SHIFT) + 64'd1) / KEPT_LEN;
    localparam int PROD_W    = SUM_W + DIV_SHIFT;

    // input register
    logic                   r_v;
    logic [CHAN_W-1:0]      r_ch;
    logic [SAMPLE_BITS-1:0] r_s;

    // window state
    logic [COUNT_W-1:0]     r_count [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_held  [CHANNELS][HELD_LEN];

    // result register
    logic              r_out_valid;
    logic [CHAN_W-1:0] r_out_ch;
    logic [MEAN_W-1:0] r_out_mean;

    logic [EXT_W-1:0]       in_ext;
    logic [CH_IDX_W-1:0]    idx;
    logic                   in_range;
    logic [COUNT_W-1:0]     cur_count;
    logic                   fires;
    logic                   out_free;
    logic                   st1_go;
    logic [SAMPLE_BITS-1:0] win [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0] lo_a, lo_b, lo_c, lo_min;
    logic [SAMPLE_BITS-1:0] hi_a, hi_b, hi_c, hi_max;
    logic [TOTAL_W-1:0]     total;
    logic [SUM_W-1:0]       mid_sum;
    logic [PROD_W-1:0]      prod;
    logic [MEAN_W-1:0]      n_mean;

    assign in_ext    = EXT_W'(i_s_axis_tdata[SAMPLE_IN_W-1:0]);
    assign idx       = r_ch[CH_IDX_W-1:0];
    assign in_range  = (32'(r_ch) < CHANNELS);
    assign cur_count = r_count[idx];
    assign fires     = in_range && (cur_count == COUNT_W'(HELD_LEN));
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign st1_go    = r_v && (!fires || out_free);

    assign o_s_axis_tready = !r_v || st1_go;

    always_comb begin
        for (int k = 0; k < HELD_LEN; k++) begin
            win[k] = r_held[idx][k];
        end
        win[HELD_LEN] = r_s;
    end

    // min and max of five as small trees
    always_comb begin
        lo_a   = (win[0] < win[1]) ? win[0] : win[1];
        hi_a   = (win[0] < win[1]) ? win[1] : win[0];
        lo_b   = (win[2] < win[3]) ? win[2] : win[3];
        hi_b   = (win[2] < win[3]) ? win[3] : win[2];
        lo_c   = (lo_a < lo_b) ? lo_a : lo_b;
        hi_c   = (hi_a > hi_b) ? hi_a : hi_b;
        lo_min = (lo_c < win[4]) ? lo_c : win[4];
        hi_max = (hi_c > win[4]) ? hi_c : win[4];
        total  = TOTAL_W'(win[0]) + TOTAL_W'(win[1]) + TOTAL_W'(win[2])
               + TOTAL_W'(win[3]) + TOTAL_W'(win[4]);
        mid_sum = SUM_W'(total - TOTAL_W'(lo_min) - TOTAL_W'(hi_max));
        prod    = PROD_W'(mid_sum) * PROD_W'(DIV_MULT);
        n_mean  = MEAN_W'(prod >> DIV_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_ch <= i_s_axis_tuser;
            r_s  <= in_ext[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
            end
        end else if (st1_go && in_range) begin
            if (fires) begin
                r_count[idx] <= '0;
            end else begin
                r_count[idx] <= cur_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (st1_go && in_range && !fires) begin
            r_held[idx][cur_count[SLOT_W-1:0]] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st1_go && fires) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st1_go && fires) begin
            r_out_ch   <= r_ch;
            r_out_mean <= n_mean;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ch;
    assign o_m_axis_tdata  = MDATA_W'(r_out_mean);

`include "trimmed_mean_of_five_assert.svh"

    `TMOF_ASSERT_NOW(a_count_bound, r_v && in_range, cur_count <= COUNT_W'(HELD_LEN), "window count above four")
    `TMOF_ASSERT_NOW(a_no_overwrite, st1_go && fires, out_free, "pending result overwritten")
    `TMOF_ASSERT_NEXT(a_fire_result, st1_go && fires, r_out_valid && (r_out_ch == $past(r_ch)), "completed window gave no result")
    `TMOF_ASSERT_NEXT(a_count_clear, st1_go && fires, r_count[$past(idx)] == '0, "window count not cleared")

endmodule

// File: bench/testbench.sv
// Self-checking bench for the per-channel trimmed mean of five filter.
module testbench;
    import tmof_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL   = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int PHASES      = 4;
    localparam int N_ROWS      = 24;
    localparam logic [SAMPLE_IN_W-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [CHAN_W-1:0]      chan;
        logic [SAMPLE_IN_W-1:0] sample;
        logic                   typed;
        logic [MEAN_W-1:0]      mean;
    } t_stim_row;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [MEAN_W-1:0] mean;
    } t_mean_result;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [CHAN_W-1:0]  i_s_axis_tuser  = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [MDATA_W-1:0] o_m_axis_tdata;
    logic [CHAN_W-1:0]  o_m_axis_tuser;

    // Predictor state: window contents and fill level per channel
    logic [SAMPLE_IN_W-1:0] win_held [CHANNELS_DEF][HELD_LEN];
    int unsigned            win_fill [CHANNELS_DEF];
    t_mean_result           means_due[$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    int tx_idle_by_phase  [PHASES] = '{0, 55, 0, 32};
    int rx_stall_by_phase [PHASES] = '{0, 0, 55, 32};

    // chan, sample, typed result, typed mean
    t_stim_row directed_rows [N_ROWS] = '{
        '{4'd0,  12'hFFF, 1'b0, 12'd0},
        '{4'd0,  12'hFFF, 1'b0, 12'd0},
        '{4'd0,  12'hFFF, 1'b0, 12'd0},
        '{4'd0,  12'hFFF, 1'b0, 12'd0},
        '{4'd0,  12'hFFF, 1'b1, 12'd4095},
        '{4'd15, 12'hABC, 1'b0, 12'd0},
        '{4'd12, 12'h555, 1'b0, 12'd0},
        '{4'd11, 12'h000, 1'b0, 12'd0},
        '{4'd11, 12'h000, 1'b0, 12'd0},
        '{4'd11, 12'h000, 1'b0, 12'd0},
        '{4'd11, 12'h000, 1'b0, 12'd0},
        '{4'd11, 12'h000, 1'b1, 12'd0},
        // interleaved windows: ties on ch1, truncation on ch2
        '{4'd1,  12'd7,   1'b0, 12'd0},
        '{4'd2,  12'd1,   1'b0, 12'd0},
        '{4'd1,  12'd7,   1'b0, 12'd0},
        '{4'd2,  12'd2,   1'b0, 12'd0},
        '{4'd1,  12'd3,   1'b0, 12'd0},
        '{4'd2,  12'd2,   1'b0, 12'd0},
        '{4'd1,  12'd7,   1'b0, 12'd0},
        '{4'd2,  12'd9,   1'b0, 12'd0},
        '{4'd1,  12'd7,   1'b0, 12'd0},
        '{4'd2,  12'd0,   1'b0, 12'd0},
        '{4'd13, 12'h800, 1'b0, 12'd0},
        '{4'd14, 12'h7FF, 1'b0, 12'd0}
    };

    trimmed_mean_of_five DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Steps the window model; returns 1 when the item closes a window.
    function automatic bit window_mean(input logic [CHAN_W-1:0] chan,
                                       input logic [SAMPLE_IN_W-1:0] sample,
                                       output t_mean_result res);
        logic [SAMPLE_IN_W-1:0] s;
        int unsigned lo, hi, total, v;
        s = sample & SAMPLE_IN_W'((1 << SAMPLE_BITS_DEF) - 1);
        res = '0;
        if (chan >= CHANNELS_DEF) return 1'b0;
        if (win_fill[chan] < HELD_LEN) begin
            win_held[chan][win_fill[chan]] = s;
            win_fill[chan]++;
            return 1'b0;
        end
        lo = s;
        hi = s;
        total = s;
        for (int k = 0; k < HELD_LEN; k++) begin
            v = win_held[chan][k];
            total += v;
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        win_fill[chan] = 0;
        res.chan = chan;
        res.mean = MEAN_W'((total - lo - hi) / KEPT_LEN);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic [SAMPLE_IN_W-1:0] sample,
                               input logic typed, input logic [MEAN_W-1:0] typed_mean);
        t_mean_result res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tuser  <= CHAN_W'($urandom);
            i_s_axis_tdata  <= {{(DATA_W-SAMPLE_IN_W){1'b0}}, SAMPLE_IN_W'($urandom)};
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= chan;
        i_s_axis_tdata  <= {{(DATA_W-SAMPLE_IN_W){1'b0}}, sample};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (window_mean(chan, sample, res)) begin
            if (typed) res.mean = typed_mean;
            means_due.push_back(res);
        end
    endtask

    task automatic check_mean_result();
        t_mean_result want;
        if (means_due.size() == 0) begin
            report_mismatch("unexpected result, channel", int'(o_m_axis_tuser), -1);
        end else begin
            want = means_due.pop_front();
            if (o_m_axis_tuser !== want.chan)
                report_mismatch("out_channel", int'(o_m_axis_tuser), int'(want.chan));
            if (o_m_axis_tdata !== MDATA_W'(want.mean))
                report_mismatch("mean", int'(o_m_axis_tdata), int'(want.mean));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) check_mean_result();
        i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int taken;
        int phase;
        int burst;
        int pick;
        logic [CHAN_W-1:0]      chan;
        logic [SAMPLE_IN_W-1:0] sample;
        logic [SAMPLE_IN_W-1:0] prev_sample;

        taken = 0;
        phase = 0;
        prev_sample = '0;
        for (int c = 0; c < CHANNELS_DEF; c++) win_fill[c] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            send_sample(directed_rows[r].chan, directed_rows[r].sample,
                        directed_rows[r].typed, directed_rows[r].mean);
            taken++;
        end

        while (taken < ITEM_GOAL) begin
            if (taken * PHASES / ITEM_GOAL != phase) begin
                phase = taken * PHASES / ITEM_GOAL;
                // drain everything before switching idle and stall patterns
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (means_due.size() != 0);
            end
            tx_idle_pct  = tx_idle_by_phase[phase];
            rx_stall_pct = rx_stall_by_phase[phase];

            pick = $urandom_range(99);
            if (pick < 12) begin
                chan  = CHAN_W'($urandom_range(15, CHANNELS_DEF));
                burst = 1;
            end else begin
                chan  = CHAN_W'($urandom_range(CHANNELS_DEF - 1));
                burst = (pick < 50) ? $urandom_range(5, 1) : 1;
            end
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 70)      sample = SAMPLE_IN_W'($urandom);
                else if (pick < 80) sample = '0;
                else if (pick < 90) sample = SAMPLE_MAX;
                else                sample = prev_sample;  // forces ties
                prev_sample = sample;
                send_sample(chan, sample, 1'b0, '0);
                taken++;
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (means_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
